// File: src/evr_pkg.sv
`default_nettype none
package evr_pkg;

  localparam int VALUE_W   = 32;              // value width
  localparam int FRAC_BITS = 16;              // fraction bits of values and of t
  localparam int TIME_W    = 32;              // time field width
  localparam int LEN_W     = TIME_W - 1;      // nonnegative time
  localparam int DIFF_W    = VALUE_W + 1;     // end - start
  localparam int T_W       = FRAC_BITS + 1;   // t in [0, ONE]
  localparam int U_W       = FRAC_BITS + 2;   // 3*ONE - 2*t
  localparam int PROD_W    = DIFF_W + U_W + 1;
  localparam int CNT_W     = (T_W > 1) ? $clog2(T_W) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV_INIT,
    ST_DIV,
    ST_CHECK,
    ST_MUL_S,
    ST_MUL_U,
    ST_EASE,
    ST_MUL_D,
    ST_ADD,
    ST_DONE
  } state_e;

  localparam logic REQ_ADVANCE  = 1'b0;
  localparam logic REQ_RETARGET = 1'b1;

endpackage
`default_nettype wire

// File: src/eased_value_ramp.sv
`default_nettype none
// A zero-length ramp skips the divider; otherwise the 17-step restoring divider for t
// runs, and unless t lands on zero or one, one shared multiplier runs up to three
// products (one for a linear ramp, three with easing).
// One word at a time: the next input word is taken the cycle after its predecessor
// is written to the output register. Async active-low
// reset clears the ramp state (start, end, length, elapsed, mode) to zero.
module eased_value_ramp (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [0:0]                            req_type_i,
  input  wire  signed [evr_pkg::TIME_W-1:0]     delta_time_i,
  input  wire  signed [evr_pkg::VALUE_W-1:0]    target_value_i,
  input  wire  signed [evr_pkg::TIME_W-1:0]     ramp_time_i,
  input  wire  [0:0]                            use_easing_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [evr_pkg::VALUE_W-1:0]    current_value_o
);
  import evr_pkg::*;

  localparam logic [U_W-1:0] THREE_ONE = U_W'(3) << FRAC_BITS;

  state_e state_q, state_d;

  // ramp state
  logic [VALUE_W-1:0] start_q, end_q;
  logic [LEN_W-1:0]   len_q, elapsed_q;
  logic               smooth_q;

  // captured request
  logic               req_type_q;
  logic [TIME_W-1:0]  dt_q, ramp_q;
  logic [VALUE_W-1:0] target_q;
  logic               ease_q;

  // divider
  logic [LEN_W:0]     rem_q;
  logic               dbit_q;
  logic [T_W-1:0]     t_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [LEN_W:0]     trial;
  logic               ge;

  // shared multiplier
  logic signed [DIFF_W-1:0] mul_a;
  logic [U_W-1:0]           mul_b;
  logic signed [U_W:0]      mul_bs;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DIFF_W-1:0] diff_q;

  logic [VALUE_W-1:0] result_q;
  logic               out_valid_q;
  logic [VALUE_W-1:0] out_q;

  logic               in_acc, out_load;
  logic [LEN_W:0]     sum;
  logic [LEN_W-1:0]   dt_nn, ramp_nn;
  logic [U_W-1:0]     u_val;

  assign in_acc = in_valid_i && (state_q == ST_IDLE);

  assign trial = {rem_q[LEN_W-1:0], dbit_q};
  assign ge    = (trial >= {1'b0, len_q});

  assign dt_nn   = dt_q[TIME_W-1] ? '0 : dt_q[LEN_W-1:0];
  assign ramp_nn = ramp_q[TIME_W-1] ? '0 : ramp_q[LEN_W-1:0];
  assign sum     = {1'b0, elapsed_q} + {1'b0, dt_nn};
  assign u_val   = THREE_ONE - {t_q, 1'b0};

  always_comb begin
    case (state_q)
      ST_MUL_S: begin
        mul_a = {{(DIFF_W-T_W){1'b0}}, t_q};
        mul_b = {{(U_W-T_W){1'b0}}, t_q};
      end
      ST_MUL_U: begin
        mul_a = {{(DIFF_W-T_W){1'b0}}, prod_q[FRAC_BITS +: T_W]};
        mul_b = u_val;
      end
      default: begin
        mul_a = diff_q;
        mul_b = {{(U_W-T_W){1'b0}}, t_q};
      end
    endcase
  end

  assign mul_bs = {1'b0, mul_b};
  assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_bs);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_UPD;
      end
      ST_UPD:      state_d = ST_DIV_INIT;
      ST_DIV_INIT: state_d = (len_q == '0) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (cnt_q == CNT_W'(T_W - 1)) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (t_q == '0 || t_q[FRAC_BITS]) begin
          state_d = ST_DONE;
        end else if (smooth_q) begin
          state_d = ST_MUL_S;
        end else begin
          state_d = ST_MUL_D;
        end
      end
      ST_MUL_S: state_d = ST_MUL_U;
      ST_MUL_U: state_d = ST_EASE;
      ST_EASE:  state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_ADD;
      ST_ADD:   state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ramp state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      end_q       <= '0;
      len_q       <= '0;
      elapsed_q   <= '0;
      smooth_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_UPD && req_type_q == REQ_ADVANCE) begin
        elapsed_q <= (sum > {1'b0, len_q}) ? len_q : sum[LEN_W-1:0];
      end
      if (out_load && req_type_q == REQ_RETARGET) begin
        start_q   <= result_q;
        end_q     <= target_q;
        len_q     <= ramp_nn;
        elapsed_q <= '0;
        smooth_q  <= ease_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_type_q <= req_type_i;
      dt_q       <= delta_time_i;
      target_q   <= target_value_i;
      ramp_q     <= ramp_time_i;
      ease_q     <= use_easing_i;
    end
    case (state_q)
      ST_DIV_INIT: begin
        // quotient of (elapsed << FRAC_BITS) / length needs FRAC_BITS+1 steps
        rem_q    <= {2'b00, elapsed_q[LEN_W-1:1]};
        dbit_q   <= elapsed_q[0];
        t_q      <= '0;
        cnt_q    <= '0;
        result_q <= end_q;
      end
      ST_DIV: begin
        rem_q  <= ge ? (trial - {1'b0, len_q}) : trial;
        dbit_q <= 1'b0;
        t_q    <= {t_q[T_W-2:0], ge};
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      ST_CHECK: begin
        diff_q   <= {end_q[VALUE_W-1], end_q} - {start_q[VALUE_W-1], start_q};
        result_q <= (t_q == '0) ? start_q : end_q;
      end
      ST_MUL_S, ST_MUL_U, ST_MUL_D: begin
        prod_q <= mul_p;
      end
      ST_EASE: begin
        t_q <= prod_q[FRAC_BITS +: T_W];
      end
      ST_ADD: begin
        result_q <= start_q + prod_q[FRAC_BITS +: VALUE_W];
      end
      default: begin
      end
    endcase
    if (out_load) begin
      // a retarget with zero length lands on its end value at once
      out_q <= (req_type_q == REQ_RETARGET && ramp_nn == '0) ? target_q : result_q;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign current_value_o = out_q;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import evr_pkg::*;

  localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [63:0] T_ONE    = 64'd1 << FRAC_BITS;
  localparam int          N_RANDOM = 325;     // per phase
  localparam int          N_PHASES = 4;

  typedef struct {
    logic [0:0]  req;
    logic [31:0] dt;
    logic [31:0] tv;
    logic [31:0] rt;
    logic [0:0]  ue;
    bit          typed;     // expected value given in the table
    logic [31:0] want;
  } ramp_word_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [0:0]                req_type_i;
  logic signed [TIME_W-1:0]  delta_time_i;
  logic signed [VALUE_W-1:0] target_value_i;
  logic signed [TIME_W-1:0]  ramp_time_i;
  logic [0:0]                use_easing_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [VALUE_W-1:0] current_value_o;

  eased_value_ramp dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .delta_time_i    (delta_time_i),
    .target_value_i  (target_value_i),
    .ramp_time_i     (ramp_time_i),
    .use_easing_i    (use_easing_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .current_value_o (current_value_o)
  );

  // predictor state
  logic signed [31:0] ramp_start;
  logic signed [31:0] ramp_end;
  logic [30:0]        ramp_len;
  logic [30:0]        ramp_elapsed;
  logic               ramp_eased;

  logic [31:0] expected_values[$];
  ramp_word_t  directed_rows[$];
  int          err_count;
  int          idle_pct;
  int          stall_pct;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [31:0] ramp_value();
    logic [63:0]        frac;
    logic [63:0]        sq;
    logic signed [63:0] span;
    logic signed [63:0] step;
    if (ramp_len == 0) return ramp_end;
    frac = ({33'd0, ramp_elapsed} << FRAC_BITS) / {33'd0, ramp_len};
    if (frac == 0) return ramp_start;
    if (frac >= T_ONE) return ramp_end;
    if (ramp_eased) begin
      sq   = (frac * frac) >> FRAC_BITS;
      frac = (sq * (3 * T_ONE - 2 * frac)) >> FRAC_BITS;
    end
    span = ramp_end - ramp_start;
    step = (span * $signed(frac)) >>> FRAC_BITS;
    return ramp_start + step[31:0];
  endfunction

  function automatic logic [31:0] ramp_apply(ramp_word_t w);
    logic [31:0] sum;
    if (w.req == REQ_RETARGET) begin
      ramp_start   = ramp_value();
      ramp_end     = w.tv;
      ramp_len     = w.rt[31] ? 31'd0 : w.rt[30:0];
      ramp_elapsed = '0;
      ramp_eased   = w.ue;
    end else begin
      // negative step counts as zero, elapsed saturates at the length
      sum = {1'b0, ramp_elapsed} + (w.dt[31] ? 32'd0 : {1'b0, w.dt[30:0]});
      if (sum > {1'b0, ramp_len}) sum = {1'b0, ramp_len};
      ramp_elapsed = sum[30:0];
    end
    return ramp_value();
  endfunction

  task automatic add_row(input logic [0:0] req, input logic [31:0] dt, input logic [31:0] tv,
                         input logic [31:0] rt, input logic [0:0] ue, input bit typed,
                         input logic [31:0] want);
    ramp_word_t w;
    w.req   = req;
    w.dt    = dt;
    w.tv    = tv;
    w.rt    = rt;
    w.ue    = ue;
    w.typed = typed;
    w.want  = want;
    directed_rows.insert(directed_rows.size(), w);
  endtask

  function automatic ramp_word_t random_word();
    ramp_word_t  w;
    int unsigned sel;
    int unsigned reach;
    w.req   = ($urandom_range(99) < 20) ? REQ_RETARGET : REQ_ADVANCE;
    w.tv    = $urandom;
    w.ue    = $urandom_range(1);
    w.typed = 0;
    w.want  = '0;
    sel = $urandom_range(99);
    if (sel < 75)      w.rt = $urandom_range(32'h0008_0000, 1);
    else if (sel < 85) w.rt = $urandom;
    else if (sel < 92) w.rt = '0;
    else               w.rt = 32'h8000_0000 | $urandom;
    // steps mostly a slice of the current ramp so the walk crosses it
    reach = (ramp_len >> 3) + 1;
    sel = $urandom_range(99);
    if (sel < 70)      w.dt = $urandom_range(reach, 0);
    else if (sel < 80) w.dt = $urandom;
    else if (sel < 90) w.dt = 32'h8000_0000 | $urandom;
    else               w.dt = $urandom_range(3, 0);
    return w;
  endfunction

  task automatic send_word(input ramp_word_t w);
    logic [31:0] pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i     <= 1'b0;
      req_type_i     <= $urandom_range(1);
      delta_time_i   <= $urandom;
      target_value_i <= $urandom;
      ramp_time_i    <= $urandom;
      use_easing_i   <= $urandom_range(1);
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= w.req;
    delta_time_i   <= w.dt;
    target_value_i <= w.tv;
    ramp_time_i    <= w.rt;
    use_easing_i   <= w.ue;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = ramp_apply(w);
    expected_values.insert(expected_values.size(), w.typed ? w.want : pred);
  endtask

  task automatic drain();
    while (expected_values.size() != 0) @(posedge clk_i);
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, current_value_o);
        err_count++;
      end else begin
        logic [31:0] exp_val;
        exp_val = expected_values.pop_front();
        if (current_value_o !== exp_val) begin
          $display("%0t: current_value mismatch: expected %h, got %h",
                   $time, exp_val, current_value_o);
          err_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    ramp_start     = '0;
    ramp_end       = '0;
    ramp_len       = '0;
    ramp_elapsed   = '0;
    ramp_eased     = 1'b0;
    err_count      = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_stall_i    = 1'b0;
    req_type_i     = '0;
    delta_time_i   = '0;
    target_value_i = '0;
    ramp_time_i    = '0;
    use_easing_i   = '0;

    //      type          delta_time    target        ramp_time     ease typed want
    add_row(REQ_ADVANCE,  32'h0,        32'h0,        32'h0,        0, 1, 32'h0);
    add_row(REQ_RETARGET, 32'h0,        VAL_MAX,      32'h0,        0, 1, VAL_MAX);
    add_row(REQ_RETARGET, 32'h1234,     VAL_MIN,      32'hFFFF_FFFF, 1, 1, VAL_MIN);
    add_row(REQ_RETARGET, 32'h0,        VAL_MAX,      32'h0001_0000, 0, 1, VAL_MIN);
    add_row(REQ_ADVANCE,  32'h0000_8000, 32'h0,       32'h0,        1, 0, 32'h0);
    add_row(REQ_ADVANCE,  VAL_MIN,      VAL_MAX,      VAL_MAX,      1, 0, 32'h0);
    add_row(REQ_ADVANCE,  VAL_MAX,      32'h0,        32'h0,        0, 1, VAL_MAX);
    add_row(REQ_RETARGET, 32'hFFFF_FFFF, VAL_MIN,     VAL_MAX,      1, 1, VAL_MAX);
    add_row(REQ_ADVANCE,  32'h4000_0000, 32'h0,       32'h0,        0, 0, 32'h0);
    add_row(REQ_ADVANCE,  32'h1,        32'h0,        32'h0,        0, 0, 32'h0);
    add_row(REQ_ADVANCE,  32'h3FFF_FFFF, 32'h0,       32'h0,        0, 1, VAL_MIN);
    add_row(REQ_RETARGET, 32'h0,        32'h1234_5678, 32'h1,       0, 1, VAL_MIN);
    add_row(REQ_ADVANCE,  32'h1,        32'h0,        32'h0,        0, 1, 32'h1234_5678);
    add_row(REQ_RETARGET, 32'h0,        32'hFFFB_0000, 32'h0003_0000, 1, 1, 32'h1234_5678);
    add_row(REQ_ADVANCE,  32'h0000_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'h0);
    add_row(REQ_ADVANCE,  32'h0000_8000, 32'h0,       32'h0,        1, 0, 32'h0);
    add_row(REQ_ADVANCE,  32'h0000_8000, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 32'h0);
    add_row(REQ_ADVANCE,  32'h0000_8000, 32'h0,       32'h0,        0, 0, 32'h0);
    add_row(REQ_ADVANCE,  32'h0001_0000, 32'h0,       32'h0,        0, 0, 32'h0);
    add_row(REQ_ADVANCE,  VAL_MAX,      32'h0,        32'h0,        0, 1, 32'hFFFB_0000);
    add_row(REQ_RETARGET, 32'h0,        32'h0,        32'hFFFF_0000, 0, 1, 32'h0);
    add_row(REQ_ADVANCE,  32'h0,        32'h0,        32'h0,        0, 1, 32'h0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_word(directed_rows[i]);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      for (int n = 0; n < N_RANDOM; n++) send_word(random_word());
      // sender holds off until every word is back
      in_valid_i <= 1'b0;
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (err_count == 0 && expected_values.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
